/* rtl/owtrs_pkg.sv */
// Shared types and constants for the one-wire temperature read sequencer.
`timescale 1ns / 1ps

package owtrs_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [15:0] IDLE_PERIOD = 16'd31250;
   localparam logic [4:0]  WRITE_LAST  = 5'd17;
   localparam logic [5:0]  READ_LAST   = 6'd33;

   localparam logic [2:0] CS_STOP   = 3'd0;
   localparam logic [2:0] CS_DIV1   = 3'd1;
   localparam logic [2:0] CS_DIV256 = 3'd4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SKIP_ROM_COMMAND      = 3'd0,
      CSR_CONVERT_COMMAND       = 3'd1,
      CSR_READ_COMMAND          = 3'd2,
      CSR_RESET_LOW_TICKS       = 3'd3,
      CSR_PRESENCE_WAIT_TICKS   = 3'd4,
      CSR_WRITE_HALF_SLOT_TICKS = 3'd5,
      CSR_READ_HALF_SLOT_TICKS  = 3'd6,
      CSR_CONVERT_WAIT_TICKS    = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      PHASE_IDLE      = 4'd0,
      PHASE_RESET1    = 4'd1,
      PHASE_SKIP1     = 4'd2,
      PHASE_CONVERT   = 4'd3,
      PHASE_WAIT      = 4'd4,
      PHASE_RESET2    = 4'd5,
      PHASE_SKIP2     = 4'd6,
      PHASE_READ_CMD  = 4'd7,
      PHASE_READ_SLOT = 4'd8
   } phase_type;

   typedef struct packed {
      logic [7:0]  skip_rom_command;
      logic [7:0]  convert_command;
      logic [7:0]  read_command;
      logic [15:0] reset_low_ticks;
      logic [15:0] presence_wait_ticks;
      logic [15:0] write_half_slot_ticks;
      logic [15:0] read_half_slot_ticks;
      logic [15:0] convert_wait_ticks;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [1:0]  reset_step;
      logic [4:0]  write_step;
      logic [5:0]  read_step;
      logic [15:0] read_word;
      logic        drive_enable;
      logic        drive_level;
      logic        ready_flag;
   } state_type;

   typedef struct packed {
      logic        line_output_enable;
      logic        line_level;
      logic        short_low_pulse;
      logic        timer_reload;
      logic [15:0] timer_period;
      logic [2:0]  timer_clock_select;
      logic        presence_missing;
      logic        result_ready;
      logic [15:0] result_word;
   } result_type;

endpackage

/* rtl/one_wire_temperature_read_sequencer.sv */
// Top level of the one-wire temperature read sequencer.
//
// Request channel (req_valid/req_stall): each transaction is either a start
// (req_func = 1) or one timer compare tick (req_func = 0) with the wire level
// sampled at that tick in req_sensed_level.
// Response channel (rsp_valid/rsp_stall): exactly one transaction per request,
// carrying the wire drive state, any timer reprogramming, the presence flag,
// and the assembled read word with its ready flag.
// A response is registered: a request accepted at one edge is presented on
// rsp_* after that edge. One transaction per cycle is taken while the
// receiver does not stall. When the receiver stalls, the response register
// holds and req_stall rises only while that held response is still waiting
// (or in reset); a new request is taken in the same cycle the held response
// leaves. Reset (synchronous, active high) empties the response register,
// returns the sequencer to idle with the wire driven high, and loads the
// default timing and command registers. csr_* writes take effect at once;
// the user makes them only while idle, and the block does not enforce it.
`timescale 1ns / 1ps

module one_wire_temperature_read_sequencer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [owtrs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [owtrs_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_func,
   input  logic                                  req_sensed_level,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_line_output_enable,
   output logic                                  rsp_line_level,
   output logic                                  rsp_short_low_pulse,
   output logic                                  rsp_timer_reload,
   output logic [15:0]                           rsp_timer_period,
   output logic [2:0]                            rsp_timer_clock_select,
   output logic                                  rsp_presence_missing,
   output logic                                  rsp_result_ready,
   output logic [15:0]                           rsp_result_word
);

   owtrs_pkg::cfg_type    cfg_ff;
   owtrs_pkg::state_type  state_ff;
   owtrs_pkg::state_type  state_in;
   owtrs_pkg::result_type rsp_ff;
   owtrs_pkg::result_type rsp_in;
   logic                  rsp_valid_ff;
   logic                  req_accept;

   assign req_stall  = reset | (rsp_valid_ff & rsp_stall);
   assign req_accept = req_valid & ~req_stall;

   owtrs_step u_step (
      .cfg          (cfg_ff),
      .state        (state_ff),
      .func         (req_func),
      .sensed_level (req_sensed_level),
      .state_next   (state_in),
      .result       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.skip_rom_command      <= 8'd204;
         cfg_ff.convert_command       <= 8'd68;
         cfg_ff.read_command          <= 8'd190;
         cfg_ff.reset_low_ticks       <= 16'd9600;
         cfg_ff.presence_wait_ticks   <= 16'd1120;
         cfg_ff.write_half_slot_ticks <= 16'd480;
         cfg_ff.read_half_slot_ticks  <= 16'd288;
         cfg_ff.convert_wait_ticks    <= 16'd62500;
      end else if (csr_write_enable) begin
         case (owtrs_pkg::csr_index_type'(csr_index))
            owtrs_pkg::CSR_SKIP_ROM_COMMAND:
               cfg_ff.skip_rom_command <= csr_write_data[7:0];
            owtrs_pkg::CSR_CONVERT_COMMAND:
               cfg_ff.convert_command <= csr_write_data[7:0];
            owtrs_pkg::CSR_READ_COMMAND:
               cfg_ff.read_command <= csr_write_data[7:0];
            owtrs_pkg::CSR_RESET_LOW_TICKS:
               cfg_ff.reset_low_ticks <= csr_write_data;
            owtrs_pkg::CSR_PRESENCE_WAIT_TICKS:
               cfg_ff.presence_wait_ticks <= csr_write_data;
            owtrs_pkg::CSR_WRITE_HALF_SLOT_TICKS:
               cfg_ff.write_half_slot_ticks <= csr_write_data;
            owtrs_pkg::CSR_READ_HALF_SLOT_TICKS:
               cfg_ff.read_half_slot_ticks <= csr_write_data;
            owtrs_pkg::CSR_CONVERT_WAIT_TICKS:
               cfg_ff.convert_wait_ticks <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= owtrs_pkg::PHASE_IDLE;
         state_ff.reset_step   <= 2'd1;
         state_ff.write_step   <= 5'd0;
         state_ff.read_step    <= 6'd0;
         state_ff.read_word    <= 16'd0;
         state_ff.drive_enable <= 1'b1;
         state_ff.drive_level  <= 1'b1;
         state_ff.ready_flag   <= 1'b0;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_line_output_enable = rsp_ff.line_output_enable;
   assign rsp_line_level         = rsp_ff.line_level;
   assign rsp_short_low_pulse    = rsp_ff.short_low_pulse;
   assign rsp_timer_reload       = rsp_ff.timer_reload;
   assign rsp_timer_period       = rsp_ff.timer_period;
   assign rsp_timer_clock_select = rsp_ff.timer_clock_select;
   assign rsp_presence_missing   = rsp_ff.presence_missing;
   assign rsp_result_ready       = rsp_ff.result_ready;
   assign rsp_result_word        = rsp_ff.result_word;

   // ready word only exists while the sequencer is idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff.ready_flag |-> state_ff.phase == owtrs_pkg::PHASE_IDLE)
      else $error("ready flag set outside idle phase");

   // a start always reloads the timer with the idle period at divide by 256
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_func |=> rsp_valid_ff && rsp_ff.timer_reload &&
         rsp_ff.timer_clock_select == owtrs_pkg::CS_DIV256 &&
         rsp_ff.timer_period == owtrs_pkg::IDLE_PERIOD && !rsp_ff.result_ready)
      else $error("start transaction did not reload idle timer");

   // a delivered response with no new request empties the register
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall && !req_accept |=> !rsp_valid_ff)
      else $error("response repeated after delivery");

   // a missing presence always restarts the reset pulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.presence_missing |-> state_ff.reset_step == 2'd1 &&
         (state_ff.phase == owtrs_pkg::PHASE_RESET1 ||
          state_ff.phase == owtrs_pkg::PHASE_RESET2))
      else $error("presence missing without reset restart");

endmodule

/* rtl/owtrs_step.sv */
// Per-transaction sequencer step: next state and result for one tick or start.
`timescale 1ns / 1ps

module owtrs_step (
   input  owtrs_pkg::cfg_type    cfg,
   input  owtrs_pkg::state_type  state,
   input  logic                  func,
   input  logic                  sensed_level,
   output owtrs_pkg::state_type  state_next,
   output owtrs_pkg::result_type result
);

   logic [7:0] write_cmd;
   logic [4:0] write_pos;
   logic       write_bit;
   logic [3:0] read_pos;
   owtrs_pkg::phase_type phase_inc;

   always_comb begin
      case (state.phase)
         owtrs_pkg::PHASE_CONVERT:  write_cmd = cfg.convert_command;
         owtrs_pkg::PHASE_READ_CMD: write_cmd = cfg.read_command;
         default:                   write_cmd = cfg.skip_rom_command;
      endcase
   end

   assign write_pos = state.write_step - 5'd1;
   assign write_bit = write_cmd[write_pos[3:1]];
   assign read_pos  = state.read_step[4:1] - 4'd1;
   assign phase_inc = owtrs_pkg::phase_type'(4'(state.phase) + 4'd1);

   // next state
   always_comb begin
      state_next = state;
      if (func) begin
         state_next.ready_flag = 1'b0;
         state_next.phase      = owtrs_pkg::PHASE_RESET1;
         state_next.reset_step = 2'd1;
         state_next.write_step = 5'd0;
         state_next.read_step  = 6'd0;
      end else begin
         case (state.phase)
            owtrs_pkg::PHASE_RESET1, owtrs_pkg::PHASE_RESET2: begin
               if (state.reset_step == 2'd1) begin
                  state_next.reset_step   = 2'd2;
                  state_next.drive_enable = 1'b1;
                  state_next.drive_level  = 1'b0;
               end else if (state.reset_step == 2'd2) begin
                  state_next.reset_step   = 2'd3;
                  state_next.drive_enable = 1'b0;
                  state_next.drive_level  = 1'b1;
               end else begin
                  state_next.reset_step = 2'd1;
                  if (!sensed_level) begin
                     state_next.phase = phase_inc;
                  end
               end
            end
            owtrs_pkg::PHASE_SKIP1, owtrs_pkg::PHASE_CONVERT,
            owtrs_pkg::PHASE_SKIP2, owtrs_pkg::PHASE_READ_CMD: begin
               if (state.write_step == 5'd0) begin
                  state_next.write_step   = 5'd1;
                  state_next.drive_enable = 1'b1;
               end else if (state.write_step < owtrs_pkg::WRITE_LAST) begin
                  if (state.write_step[0]) begin
                     state_next.drive_level = write_bit;
                  end else if (!write_bit) begin
                     state_next.drive_level = 1'b1;
                  end
                  state_next.write_step = state.write_step + 5'd1;
               end else begin
                  state_next.write_step = 5'd0;
                  state_next.phase      = phase_inc;
               end
            end
            owtrs_pkg::PHASE_WAIT: begin
               state_next.phase = phase_inc;
            end
            owtrs_pkg::PHASE_READ_SLOT: begin
               if (state.read_step == 6'd0) begin
                  state_next.read_step = 6'd1;
                  state_next.read_word = 16'd0;
               end else if (state.read_step < owtrs_pkg::READ_LAST) begin
                  if (state.read_step[0]) begin
                     state_next.drive_enable = 1'b0;
                     state_next.drive_level  = 1'b1;
                  end else begin
                     state_next.read_word[read_pos] = state.read_word[read_pos] | sensed_level;
                  end
                  state_next.read_step = state.read_step + 6'd1;
               end else begin
                  state_next.read_step  = 6'd0;
                  state_next.phase      = owtrs_pkg::PHASE_IDLE;
                  state_next.ready_flag = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result fields
   always_comb begin
      result                    = '0;
      result.line_output_enable = state_next.drive_enable;
      result.line_level         = state_next.drive_level;
      result.result_ready       = state_next.ready_flag;
      result.result_word        = state_next.read_word;
      if (func) begin
         result.timer_reload       = 1'b1;
         result.timer_period       = owtrs_pkg::IDLE_PERIOD;
         result.timer_clock_select = owtrs_pkg::CS_DIV256;
      end else begin
         case (state.phase)
            owtrs_pkg::PHASE_RESET1, owtrs_pkg::PHASE_RESET2: begin
               result.timer_reload       = 1'b1;
               result.timer_clock_select = owtrs_pkg::CS_DIV1;
               if (state.reset_step == 2'd1) begin
                  result.timer_period = cfg.reset_low_ticks;
               end else if (state.reset_step == 2'd2) begin
                  result.timer_period = cfg.presence_wait_ticks;
               end else if (!sensed_level) begin
                  result.timer_period = cfg.reset_low_ticks;
               end else begin
                  result.presence_missing   = 1'b1;
                  result.timer_period       = owtrs_pkg::IDLE_PERIOD;
                  result.timer_clock_select = owtrs_pkg::CS_DIV256;
               end
            end
            owtrs_pkg::PHASE_SKIP1, owtrs_pkg::PHASE_CONVERT,
            owtrs_pkg::PHASE_SKIP2, owtrs_pkg::PHASE_READ_CMD: begin
               if (state.write_step == 5'd0) begin
                  result.timer_reload       = 1'b1;
                  result.timer_period       = cfg.write_half_slot_ticks;
                  result.timer_clock_select = owtrs_pkg::CS_DIV1;
               end else if (state.write_step < owtrs_pkg::WRITE_LAST) begin
                  result.short_low_pulse = state.write_step[0] & write_bit;
               end
            end
            owtrs_pkg::PHASE_WAIT: begin
               result.timer_reload       = 1'b1;
               result.timer_period       = cfg.convert_wait_ticks;
               result.timer_clock_select = owtrs_pkg::CS_DIV256;
            end
            owtrs_pkg::PHASE_READ_SLOT: begin
               if (state.read_step == 6'd0) begin
                  result.timer_reload       = 1'b1;
                  result.timer_period       = cfg.read_half_slot_ticks;
                  result.timer_clock_select = owtrs_pkg::CS_DIV1;
               end else if (state.read_step < owtrs_pkg::READ_LAST) begin
                  result.short_low_pulse = state.read_step[0];
               end else begin
                  result.timer_reload       = 1'b1;
                  result.timer_period       = 16'd0;
                  result.timer_clock_select = owtrs_pkg::CS_STOP;
               end
            end
            default: begin
            end
         endcase
      end
   end

endmodule
